// ===== rtl/packed_mono_canvas_blitter_top_defines.svh =====
// Assertion shorthands used by the checker module pmcb_check_mon.
`ifndef PACKED_MONO_CANVAS_BLITTER_TOP_DEFINES_SVH
`define PACKED_MONO_CANVAS_BLITTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define PMCB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define PMCB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pmcb_pkg.sv =====
package pmcb_pkg;

	localparam int CANVAS_WIDTH  = 128;
	localparam int CANVAS_HEIGHT = 64;
	localparam int PAGE_COUNT    = (CANVAS_HEIGHT + 7) / 8;
	localparam int STORE_DEPTH   = PAGE_COUNT * CANVAS_WIDTH;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int BIT_SEL_W     = 3;

	localparam int IN_TDATA_W = 24;
	localparam int PADDR_W    = 5;

	typedef enum logic [1:0] {
		OP_BLIT  = 2'd0,
		OP_PLOT  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_DRAW   = 2'd0,
		MODE_SET    = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_INVERT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_WIDTH    = 3'd2,
		REG_HEIGHT   = 3'd3,
		REG_MODE     = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} pmcb_state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic sweep;
	} ctrl_cmd_t;

	typedef struct packed {
		logic op_read;
		logic out_blocked;
		logic sweep_last;
	} dp_status_t;

	// Page times canvas width plus column.
	function automatic logic [ADDR_W-1:0] byte_addr(logic [8:0] x, logic [8:0] y);
		return ADDR_W'(int'(y[8:BIT_SEL_W]) * CANVAS_WIDTH + int'(x));
	endfunction

endpackage

// ===== rtl/packed_mono_canvas_blitter_top.sv =====
// Monochrome page canvas: 8 pages by 128 columns, eight stacked pixels per byte.
// Input words (s_*) carry an operation in s_tuser: blit mask pixel, plot pixel,
// read byte or clear canvas. Only a read gives an output word (m_*): the byte
// holding the pixel, with m_tuser set and the byte zero when off the display.
// The user writes blit origin, size and mode over the APB port while idle; the
// block itself does not enforce this. Any write to a known register restarts the
// blit cursor at the rectangle corner. Blit, plot and read each pass IDLE, where
// the canvas RAM is read, then EXEC, where the modified byte is written back or
// the output register loaded; no new word is taken until the block is in IDLE again.
// m_tvalid is registered: it rises once EXEC has loaded the output register.
// Clear runs through SWEEP, where the RAM is zeroed one byte a cycle.
// After reset the same zeroing pass runs with s_tready low;
// configuration writes are taken throughout.
// The output register lets a new word in while a read result waits; a
// following read holds in EXEC until m_tready frees the register.
module packed_mono_canvas_blitter_top import pmcb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // pos_x[7:0], pos_y[15:8], pixel_on[16], zero
	input  logic [1:0]            s_tuser,  // operation[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // page_byte[7:0]
	output logic [0:0]            m_tuser,  // out_of_range[0]
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign pready = 1'b1;

	pmcb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tuser (s_tuser),
		.s_tready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	pmcb_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata)
	);

endmodule

// ===== rtl/pmcb_ram.sv =====
module pmcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pmcb_ctrl.sv =====
module pmcb_ctrl import pmcb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] s_tuser,
	output logic       s_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	pmcb_state_t state_q, state_d;
	logic        exec_hold;

	// A read waits in EXEC while the previous word is still unclaimed.
	assign exec_hold = status.op_read && status.out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (op_t'(s_tuser) == OP_CLEAR) ? ST_SWEEP : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!exec_hold) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_SWEEP;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec   = (state_q == ST_EXEC) && !exec_hold;
		cmd.sweep  = (state_q == ST_SWEEP);
	end

endmodule

// ===== rtl/pmcb_dp.sv =====
module pmcb_dp import pmcb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic [0:0]            m_tuser,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata
);

	logic [7:0] origin_x_q, origin_y_q, width_q, height_q;
	mode_t      mode_q;
	logic [7:0] cursor_col_q, cursor_row_q;

	op_t                  op_q;
	mode_t                wmode_q;
	logic                 pix_q;
	logic                 on_q;
	logic [BIT_SEL_W-1:0] bit_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    sweep_cnt_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_oor_q;

	reg_idx_t    cfg_idx;
	logic        cfg_we;
	op_t         in_op;
	logic [7:0]  in_x, in_y;
	logic        in_pix;
	logic        rect_ok;
	logic [7:0]  cur_col, cur_row, next_col, next_row;
	logic [8:0]  tx, ty;
	logic        on_disp;
	logic [ADDR_W-1:0] in_addr;

	logic [7:0] ram_rdata, bit_mask, new_byte, ram_wdata;
	logic [ADDR_W-1:0] ram_waddr;
	logic       ram_we;
	logic       out_load;

	assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_we  = psel && penable && pwrite;

	assign in_op  = op_t'(s_tuser);
	assign in_x   = s_tdata[7:0];
	assign in_y   = s_tdata[15:8];
	assign in_pix = s_tdata[16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			mode_q     <= MODE_DRAW;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ORIGIN_X: origin_x_q <= pwdata[7:0];
				REG_ORIGIN_Y: origin_y_q <= pwdata[7:0];
				REG_WIDTH:    width_q    <= pwdata[7:0];
				REG_HEIGHT:   height_q   <= pwdata[7:0];
				REG_MODE:     mode_q     <= mode_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_ORIGIN_X: prdata = {24'd0, origin_x_q};
			REG_ORIGIN_Y: prdata = {24'd0, origin_y_q};
			REG_WIDTH:    prdata = {24'd0, width_q};
			REG_HEIGHT:   prdata = {24'd0, height_q};
			REG_MODE:     prdata = {30'd0, mode_q};
			default:      prdata = '0;
		endcase
	end

	// Cursor: restart a run when it has left the rectangle, wrap at each edge.
	assign rect_ok = (width_q != 8'd0) && (height_q != 8'd0);

	always_comb begin
		if (cursor_col_q >= width_q || cursor_row_q >= height_q) begin
			cur_col = '0;
			cur_row = '0;
		end else begin
			cur_col = cursor_col_q;
			cur_row = cursor_row_q;
		end
		next_col = cur_col + 8'd1;
		next_row = cur_row;
		if (next_col >= width_q) begin
			next_col = '0;
			next_row = cur_row + 8'd1;
			if (next_row >= height_q) begin
				next_row = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (cfg_we && cfg_idx <= REG_MODE) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (cmd.accept && in_op == OP_BLIT && rect_ok) begin
			cursor_col_q <= next_col;
			cursor_row_q <= next_row;
		end
	end

	always_comb begin
		if (in_op == OP_BLIT) begin
			tx = {1'b0, origin_x_q} + {1'b0, cur_col};
			ty = {1'b0, origin_y_q} + {1'b0, cur_row};
		end else begin
			tx = {1'b0, in_x};
			ty = {1'b0, in_y};
		end
		on_disp = (tx < 9'(CANVAS_WIDTH)) && (ty < 9'(CANVAS_HEIGHT));
		in_addr = byte_addr(tx, ty);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_op;
			wmode_q <= (in_op == OP_BLIT) ? mode_q : MODE_DRAW;
			pix_q   <= in_pix;
			// An empty rectangle drops the blit pixel outright.
			on_q    <= on_disp && (in_op != OP_BLIT || rect_ok);
			bit_q   <= ty[BIT_SEL_W-1:0];
			addr_q  <= in_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
		end else if (cmd.sweep) begin
			sweep_cnt_q <= status.sweep_last ? '0 : sweep_cnt_q + ADDR_W'(1);
		end
	end

	assign bit_mask = 8'd1 << bit_q;

	always_comb begin
		new_byte = ram_rdata;
		unique case (wmode_q)
			MODE_DRAW:   new_byte = pix_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
			MODE_SET:    if (pix_q) new_byte = ram_rdata | bit_mask;
			MODE_CLEAR:  if (pix_q) new_byte = ram_rdata & ~bit_mask;
			MODE_INVERT: if (pix_q) new_byte = ram_rdata ^ bit_mask;
			default:     new_byte = ram_rdata;
		endcase
	end

	assign ram_we    = cmd.sweep || (cmd.exec && on_q && (op_q == OP_BLIT || op_q == OP_PLOT));
	assign ram_waddr = cmd.sweep ? sweep_cnt_q : addr_q;
	assign ram_wdata = cmd.sweep ? 8'd0 : new_byte;

	pmcb_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_canvas (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.accept),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	assign out_load = cmd.exec && op_q == OP_READ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= on_q ? ram_rdata : 8'd0;
			out_oor_q  <= !on_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_oor_q;

	assign status.op_read     = (op_q == OP_READ);
	assign status.out_blocked = out_valid_q && !m_tready;
	assign status.sweep_last  = (sweep_cnt_q == ADDR_W'(STORE_DEPTH - 1));

endmodule

// ===== rtl/pmcb_check_mon.sv =====
`include "packed_mono_canvas_blitter_top_defines.svh"

module pmcb_check_mon import pmcb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [0:0] m_tuser
);

	`PMCB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")

	`PMCB_ASSERT_NOW(a_oor_zero, m_tvalid && m_tuser[0], m_tdata == 8'd0, "off-display read returned a non-zero byte")

	`PMCB_ASSERT_NEXT(a_two_cycle, s_tvalid && s_tready, !s_tready, "input accepted on consecutive cycles")

	`PMCB_ASSERT_NEXT(a_no_early_out, s_tvalid && s_tready, !$rose(m_tvalid), "output word raised in the cycle after an accept")

endmodule

bind packed_mono_canvas_blitter_top pmcb_check_mon u_check_mon (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// ===== bench/pmcb_canvas_checker.sv =====
`timescale 1ns / 1ps

module pmcb_canvas_checker import pmcb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // pos_x[7:0], pos_y[15:8], pixel_on[16], zero
	input  logic [1:0]            s_tuser,  // operation[1:0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [7:0]            m_tdata,  // page_byte[7:0]
	input  logic [0:0]            m_tuser,  // out_of_range[0]
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	output int                    mismatch_count,
	output int                    reads_outstanding
);

	localparam int BIT_IN_PAGE_MASK = 'b111;

	typedef struct packed {
		logic [7:0] page_byte;
		logic       out_of_range;
	} read_result_t;

	logic [7:0]   canvas_model [STORE_DEPTH];
	logic [7:0]   cursor_x;
	logic [7:0]   cursor_y;
	logic [7:0]   origin_x;
	logic [7:0]   origin_y;
	logic [7:0]   rect_w;
	logic [7:0]   rect_h;
	mode_t        raster_mode;
	read_result_t reads_due [$];

	function automatic bit on_canvas(int x, int y);
		return x < CANVAS_WIDTH && y < CANVAS_HEIGHT;
	endfunction

	function automatic int page_addr(int x, int y);
		return (y >> 3) * CANVAS_WIDTH + x;
	endfunction

	task automatic paint_pixel(int x, int y, mode_t rop, logic pix);
		int         a;
		logic [7:0] bm;
		a  = page_addr(x, y);
		bm = 8'd1 << (y & BIT_IN_PAGE_MASK);
		case (rop)
			MODE_DRAW:   canvas_model[a] = pix ? (canvas_model[a] | bm) : (canvas_model[a] & ~bm);
			MODE_SET:    if (pix) canvas_model[a] = canvas_model[a] | bm;
			MODE_CLEAR:  if (pix) canvas_model[a] = canvas_model[a] & ~bm;
			MODE_INVERT: if (pix) canvas_model[a] = canvas_model[a] ^ bm;
		endcase
	endtask

	task automatic blank_canvas();
		foreach (canvas_model[i]) canvas_model[i] = '0;
	endtask

	task automatic take_register_write(logic [PADDR_W-1:0] addr, logic [31:0] value);
		bit known;
		known = 1'b1;
		case (addr[PADDR_W-1:2])
			REG_ORIGIN_X: origin_x = value[7:0];
			REG_ORIGIN_Y: origin_y = value[7:0];
			REG_WIDTH:    rect_w = value[7:0];
			REG_HEIGHT:   rect_h = value[7:0];
			REG_MODE:     raster_mode = mode_t'(value[1:0]);
			default:      known = 1'b0;
		endcase
		if (known) begin
			cursor_x = '0;
			cursor_y = '0;
		end
	endtask

	task automatic take_input_word(op_t op, logic [7:0] x, logic [7:0] y, logic pix);
		int           tx;
		int           ty;
		read_result_t r;
		case (op)
			OP_BLIT: begin
				if (rect_w != 0 && rect_h != 0) begin
					if (cursor_x >= rect_w || cursor_y >= rect_h) begin
						cursor_x = '0;
						cursor_y = '0;
					end
					tx = int'(origin_x) + int'(cursor_x);
					ty = int'(origin_y) + int'(cursor_y);
					if (on_canvas(tx, ty)) paint_pixel(tx, ty, raster_mode, pix);
					cursor_x = cursor_x + 8'd1;
					if (cursor_x >= rect_w) begin
						cursor_x = '0;
						cursor_y = cursor_y + 8'd1;
						if (cursor_y >= rect_h) cursor_y = '0;
					end
				end
			end
			OP_PLOT: begin
				if (on_canvas(x, y)) paint_pixel(x, y, MODE_DRAW, pix);
			end
			OP_READ: begin
				if (on_canvas(x, y)) begin
					r.page_byte    = canvas_model[page_addr(x, y)];
					r.out_of_range = 1'b0;
				end else begin
					r.page_byte    = '0;
					r.out_of_range = 1'b1;
				end
				reads_due.push_back(r);
			end
			OP_CLEAR: blank_canvas();
		endcase
	endtask

	task automatic check_result_word(logic [7:0] got_byte, logic got_oor);
		read_result_t want;
		if (reads_due.size() == 0) begin
			$error("result word with no read outstanding: page_byte %0h out_of_range %0b",
				got_byte, got_oor);
			mismatch_count = mismatch_count + 1;
		end else begin
			want = reads_due.pop_front();
			if (got_byte !== want.page_byte) begin
				$error("page_byte: expected %0h, got %0h", want.page_byte, got_byte);
				mismatch_count = mismatch_count + 1;
			end
			if (got_oor !== want.out_of_range) begin
				$error("out_of_range: expected %0b, got %0b", want.out_of_range, got_oor);
				mismatch_count = mismatch_count + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_canvas();
			cursor_x    = '0;
			cursor_y    = '0;
			origin_x    = '0;
			origin_y    = '0;
			rect_w      = '0;
			rect_h      = '0;
			raster_mode = MODE_DRAW;
			reads_due.delete();
			mismatch_count = 0;
			reads_outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) take_register_write(paddr, pwdata);
			if (s_tvalid && s_tready)
				take_input_word(op_t'(s_tuser), s_tdata[7:0], s_tdata[15:8], s_tdata[16]);
			if (m_tvalid && m_tready) check_result_word(m_tdata, m_tuser[0]);
			reads_outstanding <= reads_due.size();
		end
	end

endmodule

// ===== bench/packed_mono_canvas_blitter_top_tb.sv =====
`timescale 1ns / 1ps

module packed_mono_canvas_blitter_top_tb import pmcb_pkg::*; ();

	localparam int REG_COUNT     = 5;
	localparam int REG_SLOTS     = (1 << PADDR_W) / 4;
	localparam int PHASES        = 16;
	localparam int PHASE_ITEMS   = 86;
	localparam int DRAIN_CYCLES  = 1100;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 40;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [7:0]            m_tdata;
	logic [0:0]            m_tuser;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	int         mismatch_count;
	int         reads_outstanding;
	bit         no_idle;
	logic [7:0] cfg_ox;
	logic [7:0] cfg_oy;
	logic [7:0] cfg_w;
	logic [7:0] cfg_h;

	packed_mono_canvas_blitter_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	pmcb_canvas_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tuser           (s_tuser),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.pready            (pready),
		.mismatch_count    (mismatch_count),
		.reads_outstanding (reads_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** packed_mono_canvas_blitter_top: FAILED **");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off once the block has words queued.
	initial begin
		int stall_left;
		int taken;
		bit held;
		stall_left = 0;
		taken      = 0;
		held       = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) taken++;
			if (!held && taken >= HOLD_AFTER && m_tvalid && s_tvalid) begin
				held       = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!no_idle && $urandom_range(0, 99) < 28) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(op_t op, logic [7:0] x, logic [7:0] y, logic pix);
		while (!no_idle && $urandom_range(0, 99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, pix, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	// Returns the bus to idle after the access before ending, so back-to-back writes never clash.
	task automatic apb_write(int addr, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(addr);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Hold until every read has returned, then let a clear sweep run out.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (reads_outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_blit(logic [7:0] ox, logic [7:0] oy, logic [7:0] w, logic [7:0] h,
			mode_t rop);
		if ($urandom_range(0, 2) == 0)
			apb_write(4 * $urandom_range(REG_COUNT, REG_SLOTS - 1), $urandom);
		apb_write(4 * int'(REG_ORIGIN_X), ($urandom & ~32'hFF) | ox);
		apb_write(4 * int'(REG_ORIGIN_Y), ($urandom & ~32'hFF) | oy);
		apb_write(4 * int'(REG_WIDTH), ($urandom & ~32'hFF) | w);
		apb_write(4 * int'(REG_HEIGHT), ($urandom & ~32'hFF) | h);
		apb_write(4 * int'(REG_MODE), ($urandom & ~32'h3) | rop);
		cfg_ox = ox;
		cfg_oy = oy;
		cfg_w  = w;
		cfg_h  = h;
	endtask

	// Half the time near the blit rectangle so reads see its pixels, otherwise on or around the canvas or anywhere.
	function automatic logic [7:0] pick_coord(logic [7:0] base, logic [7:0] span, int limit);
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5) return base + 8'($urandom_range(0, span));
		if (roll < 9) return 8'($urandom_range(0, limit));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic run_random(int count);
		int done_items;
		int roll;
		int burst;
		done_items = 0;
		while (done_items < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				burst = $urandom_range(1, 12);
				repeat (burst) send_word(OP_BLIT, 8'($urandom), 8'($urandom), 1'($urandom));
				done_items += burst;
			end else begin
				if (roll < 65)
					send_word(OP_PLOT, pick_coord(cfg_ox, cfg_w, CANVAS_WIDTH),
						pick_coord(cfg_oy, cfg_h, CANVAS_HEIGHT), 1'($urandom));
				else if (roll < 97)
					send_word(OP_READ, pick_coord(cfg_ox, cfg_w, CANVAS_WIDTH),
						pick_coord(cfg_oy, cfg_h, CANVAS_HEIGHT), 1'($urandom));
				else
					send_word(OP_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom));
				done_items++;
			end
		end
	endtask

	function automatic logic [7:0] pick_size();
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(1, 16));
	endfunction

	initial begin
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_BLIT;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		no_idle  = 1'b0;
		cfg_ox   = '0;
		cfg_oy   = '0;
		cfg_w    = '0;
		cfg_h    = '0;
		arst_n   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers give an empty rectangle, so the blit word is dropped.
		send_word(OP_READ, 8'd0, 8'd0, 1'b0);
		send_word(OP_BLIT, 8'd0, 8'd0, 1'b1);
		send_word(OP_PLOT, 8'd0, 8'd0, 1'b1);
		send_word(OP_PLOT, 8'd127, 8'd63, 1'b1);
		send_word(OP_PLOT, 8'd128, 8'd63, 1'b1);
		send_word(OP_PLOT, 8'd127, 8'd64, 1'b1);
		send_word(OP_PLOT, 8'd255, 8'd255, 1'b1);
		send_word(OP_READ, 8'd0, 8'd0, 1'b0);
		send_word(OP_READ, 8'd127, 8'd56, 1'b0);
		send_word(OP_READ, 8'd128, 8'd63, 1'b0);
		send_word(OP_READ, 8'd127, 8'd64, 1'b0);
		send_word(OP_READ, 8'd255, 8'd255, 1'b0);
		send_word(OP_PLOT, 8'd0, 8'd0, 1'b0);
		send_word(OP_READ, 8'd0, 8'd0, 1'b0);
		send_word(OP_CLEAR, 8'd0, 8'd0, 1'b0);
		send_word(OP_READ, 8'd127, 8'd63, 1'b0);
		drain_block();

		// Draw mode over the bottom-right corner: part of the rectangle falls off.
		program_blit(8'd126, 8'd62, 8'd3, 8'd3, MODE_DRAW);
		for (int i = 0; i < 9; i++) send_word(OP_BLIT, 8'd0, 8'd0, 1'(~i));
		send_word(OP_READ, 8'd126, 8'd62, 1'b0);
		send_word(OP_READ, 8'd127, 8'd63, 1'b0);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_block();
			no_idle = (phase == 6);
			case (phase)
				0: program_blit(8'd0, 8'd0, 8'd1, 8'd1, MODE_DRAW);
				1: program_blit(8'd255, 8'd255, 8'd255, 8'd255, MODE_INVERT);
				2: program_blit(8'd124, 8'd60, 8'd8, 8'd8, MODE_SET);
				3: program_blit(8'd0, 8'd0, 8'd0, 8'd5, MODE_CLEAR);
				4: program_blit(8'd3, 8'd7, 8'd5, 8'd0, MODE_DRAW);
				5: program_blit(8'd120, 8'd56, 8'd12, 8'd12, MODE_INVERT);
				default: program_blit(
					($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, CANVAS_WIDTH + 2)),
					($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, CANVAS_HEIGHT + 2)),
					pick_size(), pick_size(), mode_t'($urandom_range(0, 3)));
			endcase
			run_random(PHASE_ITEMS);
		end
		no_idle = 1'b0;
		drain_block();

		if (mismatch_count == 0) begin
			$display("** packed_mono_canvas_blitter_top: PASSED **");
		end else begin
			$display("** packed_mono_canvas_blitter_top: FAILED **");
		end
		$finish;
	end

endmodule
